// File: rtl/imh_pkg.sv
// Shared constants for the indexed min-heap priority queue.
// Command and status codes and the fixed field widths of the channels.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imh_pkg;

  localparam int VID_BITS    = 10;
  localparam int IN_KEY_BITS = 32;
  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 3;

  localparam logic [CMD_BITS-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_EXTRACT  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_DECREASE = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_PEEK     = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY       = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_SMALLER = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_ABSENT      = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_PRESENT     = 3'd5;

endpackage

`default_nettype wire

// File: rtl/imh_if.sv
// Valid/ready channel interfaces for commands and results of the heap.
// Depends on imh_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface imh_req_if import imh_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CMD_BITS-1:0]    command;
  logic [VID_BITS-1:0]    vertex_id;
  logic [IN_KEY_BITS-1:0] key;
  logic [VID_BITS-1:0]    pred_id;

  modport source (output valid, command, vertex_id, key, pred_id, input ready);
  modport sink   (input valid, command, vertex_id, key, pred_id, output ready);
endinterface

interface imh_rsp_if import imh_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [VID_BITS-1:0]    out_vertex;
  logic [IN_KEY_BITS-1:0] out_key;
  logic [VID_BITS-1:0]    out_pred;
  logic                   out_pred_valid;

  modport source (output valid, status, out_vertex, out_key, out_pred, out_pred_valid,
                  input ready);
  modport sink   (input valid, status, out_vertex, out_key, out_pred, out_pred_valid,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/imh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap priority queue with decrease-key, built around two RAMs.
// Depends on imh_pkg, imh_req_if, imh_rsp_if and imh_ram.
//
// Usage: commands arrive on the req channel (insert, extract minimum, decrease
// key, peek minimum) and every accepted command yields exactly one result
// transfer on the rsp channel, carrying a status and, for a successful
// extract or peek, the minimum vertex, its key and its recorded predecessor.
// The heap slots live in one RAM and the per-vertex position map, with its
// presence bit, in a second RAM; both have a registered read.
// The block works on one command at a time. Insert and decrease-key sift up
// level by level (read the parent, then compare and move it down); extract
// sifts down level by level (read the left child, read the right child,
// compare and move). req.ready rises in the same cycle as the result
// becomes valid. After reset the block first clears the presence bits,
// one vertex a cycle, and holds req.ready low until that is done.
// The result sits in an output register; req.ready returns as soon as the
// block is idle, even while a result waits on a stalled receiver, but the
// next result is held back until the previous one has been transferred.
`timescale 1ns / 1ps
`default_nettype none

module indexed_min_heap_decrease_key import imh_pkg::*; #(
  parameter int CAPACITY     = 1024,
  parameter int NUM_VERTICES = 1024,
  parameter int KEY_BITS     = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  imh_req_if.sink   req,
  imh_rsp_if.source rsp
);

  // Slot and count widths follow from the capacity.
  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = $clog2(NUM_VERTICES);
  // A slot entry is {pred_valid, pred, vertex, key}.
  localparam int EW = KEY_BITS + 2 * VID_BITS + 1;
  localparam int PW = SW + 1;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_TOP   = 4'd4;
  localparam logic [3:0] S_LAST  = 4'd5;
  localparam logic [3:0] S_UPRD  = 4'd6;
  localparam logic [3:0] S_UPCMP = 4'd7;
  localparam logic [3:0] S_DNL   = 4'd8;
  localparam logic [3:0] S_DNR   = 4'd9;
  localparam logic [3:0] S_DNCMP = 4'd10;
  localparam logic [3:0] S_PLACE = 4'd11;
  localparam logic [3:0] S_RESP  = 4'd12;

  logic [3:0] state;
  logic [VW-1:0] clr_cnt;
  logic [CW-1:0] count;

  // Latched command.
  logic [CMD_BITS-1:0] cmd;
  logic [VID_BITS-1:0] vid;
  logic [KEY_BITS-1:0] in_key;
  logic [VID_BITS-1:0] in_pred;

  // The entry that is being moved through the heap, and its current slot.
  logic [EW-1:0] cur;
  logic [SW-1:0] pos;

  // Left child captured during sift-down.
  logic [EW-1:0] lent;
  logic          lsel;
  logic          rgo;

  // Result being built, and the output register.
  logic [STATUS_BITS-1:0] res_status;
  logic [VID_BITS-1:0]    res_vertex;
  logic [IN_KEY_BITS-1:0] res_key;
  logic [VID_BITS-1:0]    res_pred;
  logic                   res_pv;
  logic                   out_valid;

  // RAM ports.
  logic          slot_we;
  logic [SW-1:0] slot_waddr;
  logic [EW-1:0] slot_wdata;
  logic [SW-1:0] slot_raddr;
  logic [EW-1:0] slot_rdata;
  logic          pm_we;
  logic [VW-1:0] pm_waddr;
  logic [PW-1:0] pm_wdata;
  logic [VW-1:0] pm_raddr;
  logic [PW-1:0] pm_rdata;

  imh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  imh_ram #(.WIDTH(PW), .DEPTH(NUM_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  // Fields of the slot read data and of the moving entry.
  logic [KEY_BITS-1:0] r_key;
  logic [VID_BITS-1:0] r_vert;
  logic [VID_BITS-1:0] r_pred;
  logic                r_pv;
  logic [KEY_BITS-1:0] cur_key;
  logic [VID_BITS-1:0] cur_vert;
  logic [KEY_BITS-1:0] lent_key;

  assign r_key    = slot_rdata[KEY_BITS-1:0];
  assign r_vert   = slot_rdata[KEY_BITS +: VID_BITS];
  assign r_pred   = slot_rdata[KEY_BITS + VID_BITS +: VID_BITS];
  assign r_pv     = slot_rdata[EW-1];
  assign cur_key  = cur[KEY_BITS-1:0];
  assign cur_vert = cur[KEY_BITS +: VID_BITS];
  assign lent_key = lent[KEY_BITS-1:0];

  // Heap index arithmetic. Child indexes carry two extra bits so that they
  // can be compared against the count without wrapping.
  logic [SW-1:0] parent;
  logic [SW+1:0] left_idx;
  logic [SW+1:0] right_idx;
  logic [SW+1:0] count_ext;
  logic [CW-1:0] last_cnt;

  assign parent    = (pos - 1'b1) >> 1;
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + 1'b1;
  assign count_ext = (SW + 2)'(count);
  assign last_cnt  = count - 1'b1;

  // Sift-down choice: the left child wins ties against the right one.
  logic [KEY_BITS-1:0] best_key;
  logic                dn_right;
  logic                dn_move;
  logic [EW-1:0]       dn_ent;
  logic [SW-1:0]       dn_child;

  assign best_key = lsel ? lent_key : cur_key;
  assign dn_right = rgo && (r_key < best_key);
  assign dn_move  = dn_right || lsel;
  assign dn_ent   = dn_right ? slot_rdata : lent;
  assign dn_child = dn_right ? right_idx[SW-1:0] : left_idx[SW-1:0];

  logic accept;
  logic vid_out_of_range;
  logic rsp_free;

  assign req.ready        = (state == S_IDLE);
  assign accept           = req.valid && req.ready;
  assign vid_out_of_range = ({{(32 - VID_BITS){1'b0}}, req.vertex_id} >= 32'(NUM_VERTICES));
  assign rsp_free         = !out_valid || rsp.ready;

  // RAM port control.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = pos;
    slot_wdata = cur;
    slot_raddr = '0;
    pm_we      = 1'b0;
    pm_waddr   = VW'(cur_vert);
    pm_wdata   = {1'b1, pos};
    pm_raddr   = VW'(req.vertex_id);
    case (state)
      S_CLR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_cnt;
        pm_wdata = '0;
      end
      S_LOOK: begin
        slot_raddr = pm_rdata[SW-1:0];
      end
      S_TOP: begin
        slot_raddr = last_cnt[SW-1:0];
        if (cmd == CMD_EXTRACT) begin
          pm_we    = 1'b1;
          pm_waddr = VW'(r_vert);
          pm_wdata = '0;
        end
      end
      S_UPRD: begin
        slot_raddr = parent;
      end
      S_UPCMP: begin
        if (r_key > cur_key) begin
          slot_we    = 1'b1;
          slot_wdata = slot_rdata;
          pm_we      = 1'b1;
          pm_waddr   = VW'(r_vert);
        end
      end
      S_DNL: begin
        slot_raddr = left_idx[SW-1:0];
      end
      S_DNR: begin
        slot_raddr = right_idx[SW-1:0];
      end
      S_DNCMP: begin
        if (dn_move) begin
          slot_we    = 1'b1;
          slot_wdata = dn_ent;
          pm_we      = 1'b1;
          pm_waddr   = VW'(dn_ent[KEY_BITS +: VID_BITS]);
        end
      end
      S_PLACE: begin
        slot_we = 1'b1;
        pm_we   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The output register is loaded when a result leaves S_RESP and cleared
  // once the receiver has taken it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && rsp_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      count     <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == VW'(NUM_VERTICES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd        <= req.command;
            vid        <= req.vertex_id;
            in_key     <= KEY_BITS'(req.key);
            in_pred    <= req.pred_id;
            res_status <= ST_OK;
            res_vertex <= '0;
            res_key    <= '0;
            res_pred   <= '0;
            res_pv     <= 1'b0;
            if (req.command == CMD_INSERT || req.command == CMD_DECREASE) begin
              if (vid_out_of_range) begin
                res_status <= ST_ABSENT;
                state      <= S_RESP;
              end else begin
                state <= S_LOOK;
              end
            end else if (count == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_RESP;
            end else begin
              state <= S_TOP;
            end
          end
        end
        S_LOOK: begin
          if (cmd == CMD_INSERT) begin
            if (pm_rdata[SW]) begin
              res_status <= ST_PRESENT;
              state      <= S_RESP;
            end else if (count == CW'(CAPACITY)) begin
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else begin
              cur   <= {1'b0, {VID_BITS{1'b0}}, vid, in_key};
              pos   <= count[SW-1:0];
              count <= count + 1'b1;
              state <= S_UPRD;
            end
          end else if (!pm_rdata[SW]) begin
            res_status <= ST_ABSENT;
            state      <= S_RESP;
          end else begin
            pos   <= pm_rdata[SW-1:0];
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (in_key > r_key) begin
            res_status <= ST_NOT_SMALLER;
            state      <= S_RESP;
          end else begin
            cur   <= {1'b1, in_pred, vid, in_key};
            state <= S_UPRD;
          end
        end
        S_TOP: begin
          res_vertex <= r_vert;
          res_key    <= IN_KEY_BITS'(r_key);
          res_pred   <= r_pred;
          res_pv     <= r_pv;
          if (cmd == CMD_EXTRACT) begin
            count <= last_cnt;
            pos   <= '0;
            if (last_cnt != '0) begin
              state <= S_LAST;
            end else begin
              state <= S_RESP;
            end
          end else begin
            state <= S_RESP;
          end
        end
        S_LAST: begin
          cur   <= slot_rdata;
          state <= S_DNL;
        end
        S_UPRD: begin
          if (pos == '0) begin
            state <= S_PLACE;
          end else begin
            state <= S_UPCMP;
          end
        end
        S_UPCMP: begin
          if (r_key > cur_key) begin
            pos   <= parent;
            state <= S_UPRD;
          end else begin
            state <= S_PLACE;
          end
        end
        S_DNL: begin
          if (left_idx >= count_ext) begin
            state <= S_PLACE;
          end else begin
            state <= S_DNR;
          end
        end
        S_DNR: begin
          lent  <= slot_rdata;
          lsel  <= (r_key < cur_key);
          rgo   <= (right_idx < count_ext);
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (dn_move) begin
            pos   <= dn_child;
            state <= S_DNL;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_free) begin
            rsp.status         <= res_status;
            rsp.out_vertex     <= res_vertex;
            rsp.out_key        <= res_key;
            rsp.out_pred       <= res_pred;
            rsp.out_pred_valid <= res_pv;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// File: rtl/imh_checker.sv
// Port-level assertions for the indexed min-heap, bound to the top level.
// Depends on imh_pkg and indexed_min_heap_decrease_key.
`timescale 1ns / 1ps
`default_nettype none

module imh_checker import imh_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [STATUS_BITS-1:0] status,
  input wire logic [VID_BITS-1:0]    out_vertex,
  input wire logic [IN_KEY_BITS-1:0] out_key,
  input wire logic [VID_BITS-1:0]    out_pred,
  input wire logic                   out_pred_valid
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // One command at a time: a transfer in closes the input until it is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A failed command carries an all-zero payload.
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      out_vertex == '0 && out_key == '0 && out_pred == '0 && !out_pred_valid)
    else $error("payload not zero on a failed command");

  // A predecessor shows only when one was recorded.
  a_pred_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pred_valid |-> out_pred == '0)
    else $error("predecessor without its valid bit");

endmodule

bind indexed_min_heap_decrease_key imh_checker u_imh_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .out_valid      (rsp.valid),
  .out_ready      (rsp.ready),
  .status         (rsp.status),
  .out_vertex     (rsp.out_vertex),
  .out_key        (rsp.out_key),
  .out_pred       (rsp.out_pred),
  .out_pred_valid (rsp.out_pred_valid)
);

`default_nettype wire
